// ===== rtl/vap_pkg.sv =====
// ----------------------------------------------------------------------------
// vap_pkg
// Shared types, constants and opcodes for the vector angle rotator.
// ----------------------------------------------------------------------------
package vap_pkg;

  // input fields and fraction guard bits
  localparam int FW     = 32;
  localparam int GUARD  = 8;
  // internal coordinate width: field plus guard plus headroom for gain
  localparam int IW     = FW + GUARD + 4;
  // angle accumulator width (binary angle plus two bits of range)
  localparam int ZW     = FW + 2;
  localparam int MAX_STEPS = 40;

  // cordic gain compensation, K = GAIN_K / 2^32
  localparam logic [31:0] GAIN_K = 32'd2608131496;

  // opcodes
  localparam logic [1:0] OP_APPLY   = 2'd0;
  localparam logic [1:0] OP_REVERSE = 2'd1;
  localparam logic [1:0] OP_POLAR   = 2'd2;

  // per-step arctangents, binary angle
  localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0,         32'd0,         32'd0,        32'd0,
    32'd0,         32'd0,         32'd0,         32'd0,        32'd0
  };

  // one planar pass: enable, x-z pair (else x-y), vectoring (else rotation)
  typedef struct packed {
    logic        en;
    logic        xz;
    logic        vec;
    logic [31:0] ang;
  } slot_t;

  // item in flight; the next pass to run is always slot[0]
  typedef struct packed {
    slot_t [3:0]           slot;
    logic signed [IW-1:0]  x;
    logic signed [IW-1:0]  y;
    logic signed [IW-1:0]  z;
    logic [31:0]           ou;
    logic [31:0]           ov;
  } item_t;

endpackage

// ===== rtl/vap_front.sv =====
// ----------------------------------------------------------------------------
// vap_front
// Accepts commands, decodes the op into a list of planar passes.
// ----------------------------------------------------------------------------
module vap_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           op,
  input  logic signed [31:0]   coord_x,
  input  logic signed [31:0]   coord_y,
  input  logic signed [31:0]   coord_z,
  input  logic signed [31:0]   angle_u,
  input  logic signed [31:0]   angle_v,
  output logic                 push,
  output vap_pkg::item_t       push_item,
  input  logic                 q_full
);
  import vap_pkg::*;

  logic  valid;
  item_t item;
  item_t cls;
  logic  take;
  logic  nz;

  // decode op into passes
  always_comb begin
    nz          = (angle_u != '0) || (angle_v != '0);
    cls         = '0;
    cls.x       = IW'(coord_x) <<< GUARD;
    cls.y       = IW'(coord_y) <<< GUARD;
    cls.z       = IW'(coord_z) <<< GUARD;
    unique case (op)
      OP_APPLY: begin
        cls.slot[0] = '{en: 1'b1, xz: 1'b1, vec: 1'b0, ang: angle_v};
        cls.slot[1] = '{en: 1'b1, xz: 1'b0, vec: 1'b0, ang: angle_u};
      end
      OP_REVERSE: begin
        cls.slot[0] = '{en: 1'b1, xz: 1'b0, vec: 1'b0, ang: 32'd0 - angle_u};
        cls.slot[1] = '{en: 1'b1, xz: 1'b1, vec: 1'b0, ang: 32'd0 - angle_v};
      end
      OP_POLAR: begin
        cls.slot[0] = '{en: nz, xz: 1'b1, vec: 1'b0, ang: angle_v};
        cls.slot[1] = '{en: nz, xz: 1'b0, vec: 1'b0, ang: angle_u};
        cls.slot[2] = '{en: 1'b1, xz: 1'b0, vec: 1'b1, ang: 32'd0};
        cls.slot[3] = '{en: 1'b1, xz: 1'b1, vec: 1'b1, ang: 32'd0};
      end
      default: begin
        cls.slot = '0;
      end
    endcase
  end

  // handshake
  assign push      = valid && !q_full;
  assign busy      = valid && q_full;
  assign take      = start && !busy;
  assign push_item = item;

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= cls;
    end
  end

endmodule

// ===== rtl/vap_queue.sv =====
// ----------------------------------------------------------------------------
// vap_queue
// Two-entry queue between the decode front and the cordic back end.
// ----------------------------------------------------------------------------
module vap_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  vap_pkg::item_t   push_item,
  output logic             full,
  output logic             pop,
  output vap_pkg::item_t   pop_item
);
  import vap_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign pop      = (count != 2'd0);
  assign pop_item = mem[rd_ptr];

  // pointers and fill count; the back end drains every cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/vap_plane.sv =====
// ----------------------------------------------------------------------------
// vap_plane
// One pipelined planar cordic pass (rotation or vectoring) with gain fix.
// ----------------------------------------------------------------------------
module vap_plane #(
  parameter int NSTEP = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  vap_pkg::item_t   in_item,
  output logic             out_valid,
  output vap_pkg::item_t   out_item
);
  import vap_pkg::*;

  logic                 vld   [NSTEP+1];
  logic signed [IW-1:0] a_r   [NSTEP+1];
  logic signed [IW-1:0] b_r   [NSTEP+1];
  logic signed [ZW-1:0] z_r   [NSTEP+1];
  logic                 act_r [NSTEP+1];
  item_t                it_r  [NSTEP+1];

  slot_t                s;
  logic signed [IW-1:0] a0, b0, pa, pb;
  logic signed [ZW-1:0] pz;
  logic                 pact;
  logic                 flip;

  // range reduction and sign fold ahead of the steps
  always_comb begin
    s    = in_item.slot[0];
    a0   = in_item.x;
    b0   = s.xz ? in_item.z : in_item.y;
    flip = (!s.ang[31] && s.ang[30] && (s.ang[29:0] != '0)) ||
           (s.ang[31] && !s.ang[30]);
    pa   = a0;
    pb   = b0;
    pz   = ZW'(signed'(s.ang));
    pact = s.en;
    if (s.en) begin
      if (s.vec) begin
        pz = '0;
        if (a0 == '0 && b0 == '0) begin
          pact = 1'b0;
        end else if (a0 < 0) begin
          pa = -a0;
          pb = -b0;
          pz = {2'b00, 32'h8000_0000};
        end
      end else if (flip) begin
        pa = -a0;
        pb = -b0;
        pz = ZW'(signed'({~s.ang[31], s.ang[30:0]}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    a_r[0]   <= pa;
    b_r[0]   <= pb;
    z_r[0]   <= pz;
    act_r[0] <= pact;
    it_r[0]  <= in_item;
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    logic                 m;
    logic signed [IW-1:0] as, bs;
    logic signed [ZW-1:0] at;

    assign at = {2'b00, ATAN_TAB[i]};
    assign as = a_r[i] >>> i;
    assign bs = b_r[i] >>> i;
    assign m  = it_r[i].slot[0].vec ? ~b_r[i][IW-1] : z_r[i][ZW-1];

    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else     vld[i+1] <= vld[i];
    end

    always_ff @(posedge clk) begin
      act_r[i+1] <= act_r[i];
      it_r[i+1]  <= it_r[i];
      if (act_r[i]) begin
        a_r[i+1] <= m ? a_r[i] + bs : a_r[i] - bs;
        b_r[i+1] <= m ? b_r[i] - as : b_r[i] + as;
        z_r[i+1] <= m ? z_r[i] + at : z_r[i] - at;
      end else begin
        a_r[i+1] <= a_r[i];
        b_r[i+1] <= b_r[i];
        z_r[i+1] <= z_r[i];
      end
    end
  end

  // gain: sign and magnitude
  logic                 g1_vld, g1_act, g1_na, g1_nb;
  logic [IW-1:0]        g1_ma, g1_mb;
  logic signed [IW-1:0] g1_a, g1_b;
  logic [31:0]          g1_z;
  item_t                g1_it;

  always_ff @(posedge clk) begin
    if (rst) g1_vld <= 1'b0;
    else     g1_vld <= vld[NSTEP];
  end

  always_ff @(posedge clk) begin
    g1_act <= act_r[NSTEP];
    g1_na  <= a_r[NSTEP][IW-1];
    g1_nb  <= b_r[NSTEP][IW-1];
    g1_ma  <= a_r[NSTEP][IW-1] ? unsigned'(-a_r[NSTEP]) : unsigned'(a_r[NSTEP]);
    g1_mb  <= b_r[NSTEP][IW-1] ? unsigned'(-b_r[NSTEP]) : unsigned'(b_r[NSTEP]);
    g1_a   <= a_r[NSTEP];
    g1_b   <= b_r[NSTEP];
    g1_z   <= z_r[NSTEP][31:0];
    g1_it  <= it_r[NSTEP];
  end

  // gain: partial products
  logic                 g2_vld, g2_act, g2_na, g2_nb;
  logic [IW-1:0]        g2_pha, g2_phb;
  logic [63:0]          g2_pla, g2_plb;
  logic signed [IW-1:0] g2_a, g2_b;
  logic [31:0]          g2_z;
  item_t                g2_it;

  always_ff @(posedge clk) begin
    if (rst) g2_vld <= 1'b0;
    else     g2_vld <= g1_vld;
  end

  always_ff @(posedge clk) begin
    g2_act <= g1_act;
    g2_na  <= g1_na;
    g2_nb  <= g1_nb;
    g2_pha <= g1_ma[IW-1:32] * GAIN_K;
    g2_phb <= g1_mb[IW-1:32] * GAIN_K;
    g2_pla <= g1_ma[31:0] * GAIN_K;
    g2_plb <= g1_mb[31:0] * GAIN_K;
    g2_a   <= g1_a;
    g2_b   <= g1_b;
    g2_z   <= g1_z;
    g2_it  <= g1_it;
  end

  // gain: sum, sign and write back
  logic [IW-1:0]        pa_m, pb_m;
  logic signed [IW-1:0] fa, fb;
  item_t                wb;

  always_comb begin
    pa_m = g2_pha + IW'((g2_pla + 64'h8000_0000) >> 32);
    pb_m = g2_phb + IW'((g2_plb + 64'h8000_0000) >> 32);
    fa   = g2_act ? (g2_na ? -signed'(pa_m) : signed'(pa_m)) : g2_a;
    fb   = g2_act ? (g2_nb ? -signed'(pb_m) : signed'(pb_m)) : g2_b;
    wb   = g2_it;
    wb.x = fa;
    if (g2_it.slot[0].xz) wb.z = fb;
    else                  wb.y = fb;
    if (g2_act && g2_it.slot[0].vec) begin
      if (g2_it.slot[0].xz) wb.ov = g2_z;
      else                  wb.ou = g2_z;
    end
    wb.slot = {slot_t'('0), g2_it.slot[3:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= g2_vld;
  end

  always_ff @(posedge clk) begin
    out_item <= wb;
  end

endmodule

// ===== rtl/vap_back.sv =====
// ----------------------------------------------------------------------------
// vap_back
// Four chained planar passes, then rounding and saturation of the result.
// ----------------------------------------------------------------------------
module vap_back #(
  parameter int NSTEP       = 24,
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  vap_pkg::item_t     in_item,
  output logic               done,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_u,
  output logic signed [31:0] out_v,
  output logic               saturated
);
  import vap_pkg::*;

  localparam int SATW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int RW   = IW - GUARD;
  localparam logic signed [RW-1:0] HI = RW'((64'sd1 <<< (SATW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] LO = -HI - RW'(1);

  logic  v [5];
  item_t it [5];

  assign v[0]  = in_valid;
  assign it[0] = in_item;

  // pass chain
  for (genvar p = 0; p < 4; p++) begin : g_pass
    vap_plane #(.NSTEP(NSTEP)) u_plane (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[p]),
      .in_item   (it[p]),
      .out_valid (v[p+1]),
      .out_item  (it[p+1])
    );
  end

  // round half up, clamp
  logic signed [RW-1:0] rc [3];
  logic [2:0]           clip;
  logic signed [IW-1:0] src [3];

  assign src[0] = it[4].x;
  assign src[1] = it[4].y;
  assign src[2] = it[4].z;

  for (genvar c = 0; c < 3; c++) begin : g_fin
    logic signed [IW-1:0] sum;
    logic signed [RW-1:0] r;
    assign sum = src[c] + IW'(1 << (GUARD - 1));
    assign r   = sum[IW-1:GUARD];
    always_comb begin
      rc[c]   = r;
      clip[c] = 1'b0;
      if (r > HI) begin
        rc[c]   = HI;
        clip[c] = 1'b1;
      end else if (r < LO) begin
        rc[c]   = LO;
        clip[c] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v[4];
  end

  always_ff @(posedge clk) begin
    out_x     <= rc[0][31:0];
    out_y     <= rc[1][31:0];
    out_z     <= rc[2][31:0];
    out_u     <= it[4].ou;
    out_v     <= it[4].ov;
    saturated <= |clip;
  end

endmodule

// ===== rtl/vector_angle_rotator.sv =====
// ----------------------------------------------------------------------------
// vector_angle_rotator
// Rotates a 3D vector by two binary angles, or turns it into length and
// angles, with gain-compensated cordic passes.
// ----------------------------------------------------------------------------
//  channel   signals                                  transfer when
//  command   start, busy, op, coord_*, angle_u/v      start && !busy
//  result    done, out_x/y/z, out_u/v, saturated      done (one cycle)
//
//  one command per cycle sustained, through four chained pipelined cordic
//  passes of one step a stage
//  busy rises only if the decode register and the two-entry queue both fill;
//  the back end drains one item every cycle and is never held
//  reset clears all valid flags; no clearing pass
// ----------------------------------------------------------------------------
module vector_angle_rotator #(
  parameter int CORDIC_STEPS = 24,
  parameter int COORD_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic signed [31:0] angle_u,
  input  logic signed [31:0] angle_v,
  output logic               done,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_u,
  output logic signed [31:0] out_v,
  output logic               saturated
);
  import vap_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

  logic  push, q_full, pop;
  item_t push_item, pop_item;

  // decode front
  vap_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .angle_u   (angle_u),
    .angle_v   (angle_v),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  // decoupling queue
  vap_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  // cordic back end
  vap_back #(
    .NSTEP       (NSTEP),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pop),
    .in_item   (pop_item),
    .done      (done),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_u     (out_u),
    .out_v     (out_v),
    .saturated (saturated)
  );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// vector angle rotator testbench
// Sends directed and random vectors through the command port and checks every
// result against a bit-accurate predictor of the cordic rotation and vectoring
// passes, under several sender idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import vap_pkg::*;

  localparam int STEPS     = 24;
  localparam int LATENCY   = 3 + 4 * (STEPS + 4);
  localparam int WDOG_MAX  = 20 * LATENCY + 2000;
  localparam logic [1:0] OP_PASS = 2'd3;

  typedef struct {
    logic [31:0] x, y, z, u, v;
    logic        sat;
  } vec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] op = '0;
  logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic signed [31:0] angle_u = '0, angle_v = '0;
  logic busy, done, saturated;
  logic signed [31:0] out_x, out_y, out_z, out_u, out_v;

  vec_result_t expected_q[$];
  int mismatches = 0;
  int idle_pct = 0;
  int wdog = 0;

  always #4 clk = ~clk;

  vector_angle_rotator #(.CORDIC_STEPS(STEPS), .COORD_WIDTH(32)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .angle_u(angle_u), .angle_v(angle_v), .done(done),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_u(out_u), .out_v(out_v), .saturated(saturated)
  );

  // arithmetic shift right, floor rounding
  function automatic longint shr(longint a, int s);
    return a >>> s;
  endfunction

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  // multiply by cordic gain, rounded half away from zero
  function automatic longint gain(longint a);
    logic [63:0] m, p;
    logic neg;
    neg = a < 0;
    m = neg ? 64'(-a) : 64'(a);
    p = (m >> 32) * 64'(GAIN_K) + (((m & 64'hFFFF_FFFF) * 64'(GAIN_K) + 64'h8000_0000) >> 32);
    return neg ? -longint'(p) : longint'(p);
  endfunction

  task automatic rotate(inout longint a, inout longint b, input logic [31:0] ang);
    longint zz, na, nb;
    zz = sx32(ang);
    if (zz > 64'sh4000_0000 || zz < -64'sh4000_0000) begin
      a = -a;
      b = -b;
      ang = ang + 32'h8000_0000;
      zz = sx32(ang);
    end
    for (int i = 0; i < STEPS; i++) begin
      if (zz >= 0) begin
        na = a - shr(b, i); nb = b + shr(a, i); zz -= longint'(ATAN_TAB[i]);
      end else begin
        na = a + shr(b, i); nb = b - shr(a, i); zz += longint'(ATAN_TAB[i]);
      end
      a = na; b = nb;
    end
    a = gain(a);
    b = gain(b);
  endtask

  task automatic vectorize(inout longint a, inout longint b, output logic [31:0] acc);
    longint na, nb;
    acc = '0;
    if (a == 0 && b == 0) return;
    if (a < 0) begin
      a = -a; b = -b; acc = 32'h8000_0000;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (b >= 0) begin
        na = a + shr(b, i); nb = b - shr(a, i); acc += ATAN_TAB[i];
      end else begin
        na = a - shr(b, i); nb = b + shr(a, i); acc -= ATAN_TAB[i];
      end
      a = na; b = nb;
    end
    a = gain(a);
    b = gain(b);
  endtask

  function automatic logic [31:0] clamp(longint v, inout logic sat);
    longint r;
    r = shr(v + 128, GUARD);
    if (r > 64'sh7FFF_FFFF) begin r = 64'sh7FFF_FFFF; sat = 1'b1; end
    if (r < -64'sh8000_0000) begin r = -64'sh8000_0000; sat = 1'b1; end
    return r[31:0];
  endfunction

  task automatic predict_vector(input logic [1:0] o, input logic [31:0] ix, iy, iz, iu, iv,
                                output vec_result_t res);
    longint x, y, z;
    logic [31:0] ou, ov;
    logic sat;
    x = sx32(ix) * 256; y = sx32(iy) * 256; z = sx32(iz) * 256;
    ou = '0; ov = '0; sat = 1'b0;
    case (o)
      OP_APPLY: begin
        rotate(x, z, iv); rotate(x, y, iu);
      end
      OP_REVERSE: begin
        rotate(x, y, 32'd0 - iu); rotate(x, z, 32'd0 - iv);
      end
      OP_POLAR: begin
        if (iu != 0 || iv != 0) begin
          rotate(x, z, iv); rotate(x, y, iu);
        end
        vectorize(x, y, ou);
        vectorize(x, z, ov);
      end
      default: ;
    endcase
    res.x = clamp(x, sat);
    res.y = clamp(y, sat);
    res.z = clamp(z, sat);
    res.u = ou; res.v = ov; res.sat = sat;
  endtask

  // send one command; transfer happens at the edge where start && !busy
  task automatic send_vector(input logic [1:0] o, input logic [31:0] ix, iy, iz, iu, iv);
    vec_result_t r;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    predict_vector(o, ix, iy, iz, iu, iv, r);
    start <= 1'b1; op <= o;
    coord_x <= ix; coord_y <= iy; coord_z <= iz; angle_u <= iu; angle_v <= iv;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(r);
  endtask

  task automatic go_quiet();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(6))
      0: return 32'h4000_0000;
      1: return 32'hC000_0000;
      2: return 32'h8000_0000;
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // extremes, every op, pi boundary, zero plane, negative axis, unused op
  task automatic test_directed();
    send_vector(OP_APPLY, 32'h0001_0000, 0, 0, 32'h4000_0000, 0);
    send_vector(OP_APPLY, 32'h0001_0000, 0, 0, 32'h4000_0001, 32'hBFFF_FFFF);
    send_vector(OP_APPLY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h2000_0000, 32'h2000_0000);
    send_vector(OP_APPLY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_vector(OP_REVERSE, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 32'h1234_5678, 32'hF000_0000);
    send_vector(OP_REVERSE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000);
    send_vector(OP_POLAR, 0, 0, 0, 0, 0);
    send_vector(OP_POLAR, 32'hFFFF_0000, 0, 0, 0, 0);
    send_vector(OP_POLAR, 32'h0003_0000, 32'h0004_0000, 32'h000C_0000, 0, 0);
    send_vector(OP_POLAR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    send_vector(OP_POLAR, 32'h0001_0000, 0, 0, 32'h4000_0000, 32'h1000_0000);
    send_vector(OP_POLAR, 0, 32'h8000_0000, 0, 0, 0);
    send_vector(OP_POLAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_vector(OP_PASS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'h1111_1111, 32'h2222_2222);
    send_vector(OP_PASS, 0, 0, 0, 0, 0);
    go_quiet();
  endtask

  task automatic test_random(input int pct, input int count);
    logic [1:0] o;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      o = ($urandom_range(15) == 0) ? OP_PASS : 2'($urandom_range(2));
      send_vector(o, rand_coord(), rand_coord(), rand_coord(),
                  ($urandom_range(3) == 0 && o == OP_POLAR) ? 32'd0 : rand_angle(),
                  ($urandom_range(3) == 0 && o == OP_POLAR) ? 32'd0 : rand_angle());
    end
    go_quiet();
    idle_pct = 0;
  endtask

  // result checker: each done transfer against the oldest prediction
  always @(posedge clk) begin
    vec_result_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%h", out_x);
      end else begin
        e = expected_q.pop_front();
        if (out_x !== e.x || out_y !== e.y || out_z !== e.z || out_u !== e.u ||
            out_v !== e.v || saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h %h %h %h %h %b got %h %h %h %h %h %b",
                     e.x, e.y, e.z, e.u, e.v, e.sat,
                     out_x, out_y, out_z, out_u, out_v, saturated);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(0, 450);
    test_random(77, 400);
    test_random(77, 400);
    test_random(38, 450);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== vector_angle_rotator.f =====
rtl/vap_pkg.sv
rtl/vap_front.sv
rtl/vap_queue.sv
rtl/vap_plane.sv
rtl/vap_back.sv
rtl/vector_angle_rotator.sv
dv/testbench.sv
